FILE: rtl/epoch_seconds_to_bcd_datetime_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the epoch to BCD date block
// Each macro expands to a clocked concurrent assertion, or to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_BCD_DATETIME_ASSERT_SVH
`define EPOCH_SECONDS_TO_BCD_DATETIME_ASSERT_SVH

`ifndef SYNTH

// Check a property at every clock edge outside reset.
`define EPBCD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("epbcd assertion failed");

// Check that a condition in one cycle is followed by another in the next.
`define EPBCD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("epbcd sequence assertion failed");

`else

`define EPBCD_ASSERT(name, prop)
`define EPBCD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: rtl/epbcd_pkg.sv
// ----------------------------------------------------------------------------
// epbcd_pkg
// Types, microcode program, calendar tables and digit helpers shared by the
// epoch to BCD date block.
// ----------------------------------------------------------------------------
package epbcd_pkg;

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    OpNop      = 4'd0,
    OpLoad     = 4'd1,
    OpDayQuo   = 4'd2,
    OpSplit    = 4'd3,
    OpHours    = 4'd4,
    OpMinRem   = 4'd5,
    OpMins     = 4'd6,
    OpYearBack = 4'd7,
    OpYearFwd4 = 4'd8,
    OpYearFwd1 = 4'd9,
    OpMonth    = 4'd10,
    OpEmit     = 4'd11
  } op_e;

  // Branch conditions: when true, jump to the target, else advance.
  typedef enum logic [3:0] {
    CondNever     = 4'd0,
    CondAlways    = 4'd1,
    CondNoIn      = 4'd2,
    CondDayNeg    = 4'd3,
    CondDayGe4    = 4'd4,
    CondDayGeYear = 4'd5,
    CondMonGo     = 4'd6,
    CondOutBusy   = 4'd7
  } cond_e;

  typedef logic [3:0] step_t;

  localparam step_t StepIdle   = 4'd0;
  localparam step_t StepDayQuo = 4'd1;
  localparam step_t StepSplit  = 4'd2;
  localparam step_t StepHours  = 4'd3;
  localparam step_t StepMinRem = 4'd4;
  localparam step_t StepMins   = 4'd5;
  localparam step_t StepYrBack = 4'd6;
  localparam step_t StepYrFwd4 = 4'd7;
  localparam step_t StepYrFwd1 = 4'd8;
  localparam step_t StepMonth  = 4'd9;
  localparam step_t StepEmit   = 4'd10;
  localparam step_t StepWrap   = 4'd11;
  localparam step_t StepLast   = StepWrap;

  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;

  // Days added to the signed input so the dividend is never negative.
  localparam int DayBiasInt = 24856;
  localparam logic [32:0] SecsBias = 33'(DayBiasInt) * 33'(SecsPerDay);
  localparam logic signed [16:0] DayBias = 17'(DayBiasInt);
  // Weekday of biased day 0, with Sunday as 0.
  localparam logic [16:0] WdayBias = 17'((7340036 - DayBiasInt) % 7);

  // Rounded-up reciprocals, exact over the ranges they see:
  //   86400 = 675 << 7, day = ((acc >> 7) * DayRecip) >> 35
  //   hour  = (time of day * HourRecip) >> 27
  //   min   = (seconds into the hour * MinRecip) >> 17
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam logic [15:0] HourRecip = 16'd37283;
  localparam logic [11:0] MinRecip  = 12'd2185;

  localparam logic [7:0]         EpochYear   = 8'd70;
  localparam logic signed [15:0] FourYrDays  = 16'sd1461;
  localparam logic signed [15:0] LeapYrDays  = 16'sd366;
  localparam logic signed [15:0] PlainYrDays = 16'sd365;
  localparam logic [3:0]         LastMonth   = 4'd11;
  localparam logic [3:0]         HourMode    = 4'h8;
  localparam logic [2:0]         LeapFlag    = 3'd4;

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  // Sequencer to datapath.
  typedef struct packed {
    op_e  op;
    logic idle;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic day_neg;
    logic day_ge4;
    logic day_ge_year;
    logic mon_go;
  } stat_t;

  typedef struct packed {
    logic [3:0] minute_ones;
    logic [2:0] minute_tens;
    logic [3:0] hour_ones;
    logic [3:0] hour_tens_mode;
    logic [2:0] weekday;
    logic [3:0] day_ones;
    logic [2:0] day_tens_leap;
    logic [3:0] month_ones;
    logic       month_tens;
    logic [3:0] year_ones;
    logic [3:0] year_tens;
  } res_t;

  typedef struct packed {
    logic [4:0] tens;
    logic [3:0] ones;
  } digits_t;

  // Microcode program.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t u;
    u = '{op: OpNop, cond: CondNever, target: StepIdle};
    case (s)
      StepIdle: begin
        u = '{op: OpLoad, cond: CondNoIn, target: StepIdle};
      end
      StepDayQuo: begin
        u = '{op: OpDayQuo, cond: CondNever, target: StepIdle};
      end
      StepSplit: begin
        u = '{op: OpSplit, cond: CondNever, target: StepIdle};
      end
      StepHours: begin
        u = '{op: OpHours, cond: CondNever, target: StepIdle};
      end
      StepMinRem: begin
        u = '{op: OpMinRem, cond: CondNever, target: StepIdle};
      end
      StepMins: begin
        u = '{op: OpMins, cond: CondNever, target: StepIdle};
      end
      StepYrBack: begin
        u = '{op: OpYearBack, cond: CondDayNeg, target: StepYrBack};
      end
      StepYrFwd4: begin
        u = '{op: OpYearFwd4, cond: CondDayGe4, target: StepYrFwd4};
      end
      StepYrFwd1: begin
        u = '{op: OpYearFwd1, cond: CondDayGeYear, target: StepYrFwd1};
      end
      StepMonth: begin
        u = '{op: OpMonth, cond: CondMonGo, target: StepMonth};
      end
      StepEmit: begin
        u = '{op: OpEmit, cond: CondOutBusy, target: StepEmit};
      end
      StepWrap: begin
        u = '{op: OpNop, cond: CondAlways, target: StepIdle};
      end
      default: begin
        u = '{op: OpNop, cond: CondAlways, target: StepIdle};
      end
    endcase
    return u;
  endfunction

  // Split 0..255 into tens and ones; 205/2048 is exact for this range.
  function automatic digits_t to_digits(logic [7:0] v);
    logic [15:0] p;
    logic [7:0]  r;
    digits_t     d;
    p      = 16'(v) * 16'd205;
    d.tens = p[15:11];
    r      = v - ({3'b000, d.tens} * 8'd10);
    d.ones = r[3:0];
    return d;
  endfunction

  // Residue modulo 7, folding 3-bit groups since 8 is 1 mod 7.
  function automatic logic [2:0] mod7(logic [16:0] v);
    logic [5:0] s;
    logic [3:0] s2;
    logic [3:0] r;
    s  = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
       + 6'(v[16:15]);
    s2 = 4'(s[5:3]) + 4'(s[2:0]);
    r  = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
    return r[2:0];
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] mon, logic leap);
    return MonthLen[mon] + 5'((mon == 4'd1) && leap);
  endfunction

endpackage

FILE: rtl/epbcd_if.sv
// ----------------------------------------------------------------------------
// epbcd channel interfaces
// Valid/ready channels for the epoch input beat and the BCD result beat.
// ----------------------------------------------------------------------------
interface epbcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface epbcd_out_if import epbcd_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/epbcd_seq.sv
// ----------------------------------------------------------------------------
// epbcd_seq
// Microcode sequencer: step counter, program ROM and branches.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_bcd_datetime_assert.svh"

module epbcd_seq import epbcd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  step_t  step_q, step_d;
  ucode_t uc;
  logic   taken;

  assign uc = ucode_rom(step_q);

  always_comb begin
    case (uc.cond)
      CondNever:     taken = 1'b0;
      CondAlways:    taken = 1'b1;
      CondNoIn:      taken = !stat_i.in_valid;
      CondDayNeg:    taken = stat_i.day_neg;
      CondDayGe4:    taken = stat_i.day_ge4;
      CondDayGeYear: taken = stat_i.day_ge_year;
      CondMonGo:     taken = stat_i.mon_go;
      CondOutBusy:   taken = stat_i.out_busy;
      default:       taken = 1'b0;
    endcase
  end

  assign step_d = taken ? uc.target : (step_q + step_t'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.op   = uc.op;
  assign ctrl_o.idle = (step_q == StepIdle);

  `EPBCD_ASSERT(a_step_range, step_q <= StepLast)
  `EPBCD_ASSERT_NEXT(a_accept_starts_quo, ctrl_o.idle && stat_i.in_valid,
                     step_q == StepDayQuo)
  `EPBCD_ASSERT_NEXT(a_quo_to_split, step_q == StepDayQuo,
                     step_q == StepSplit)
  `EPBCD_ASSERT_NEXT(a_emit_leaves, step_q == StepEmit && !stat_i.out_busy,
                     step_q == StepWrap)

endmodule

FILE: rtl/epbcd_dp.sv
// ----------------------------------------------------------------------------
// epbcd_dp
// Datapath: reciprocal dividers, day and year walk registers, result register.
// ----------------------------------------------------------------------------
module epbcd_dp import epbcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  input  logic               in_valid_i,
  input  logic signed [31:0] epoch_seconds_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output res_t               res_o,
  output stat_t              stat_o
);

  logic [32:0]        acc_q, acc_d;
  logic [15:0]        quo_q, quo_d;
  logic signed [15:0] day_q, day_d;
  logic [7:0]         yr_q, yr_d;
  logic [3:0]         mon_q, mon_d;
  logic [4:0]         hours_q, hours_d;
  logic [5:0]         mins_q, mins_d;
  logic [2:0]         wday_q, wday_d;
  res_t               res_q, res_d;
  logic               out_valid_q, out_valid_d;

  logic               leap;
  logic               emit;
  logic signed [15:0] year_len;
  logic signed [15:0] mon_len;
  logic signed [16:0] day_wide;
  logic [50:0]        day_prod;
  logic [32:0]        day_back;
  logic [31:0]        hour_prod;
  logic [16:0]        hour_back;
  logic [22:0]        min_prod;
  logic [7:0]         dom1;
  digits_t            d_min, d_hr, d_dom, d_mon, d_yr;

  assign leap     = (yr_q[1:0] == 2'b00);
  assign year_len = leap ? LeapYrDays : PlainYrDays;
  assign mon_len  = $signed({11'b0, month_len(mon_q, leap)});
  assign day_wide = $signed({1'b0, quo_q}) - DayBias;

  // One multiply per step; each reads registered operands.
  assign day_prod  = 51'(acc_q[32:7]) * 51'(DayRecip);
  assign day_back  = 33'(quo_q) * 33'(SecsPerDay);
  assign hour_prod = 32'(acc_q[16:0]) * 32'(HourRecip);
  assign hour_back = 17'(hours_q) * 17'(SecsPerHour);
  assign min_prod  = 23'(acc_q[11:0]) * 23'(MinRecip);

  assign stat_o.in_valid    = in_valid_i;
  assign stat_o.out_busy    = out_valid_q && !out_ready_i;
  assign stat_o.day_neg     = day_q[15];
  assign stat_o.day_ge4     = (day_q >= FourYrDays);
  assign stat_o.day_ge_year = (day_q >= year_len);
  assign stat_o.mon_go      = (mon_q < LastMonth) && (day_q >= mon_len);

  assign emit = (ctrl_i.op == OpEmit) && !stat_o.out_busy;

  // Digit split of the finished fields.
  assign dom1  = {3'b000, day_q[4:0]} + 8'd1;
  assign d_min = to_digits({2'b00, mins_q});
  assign d_hr  = to_digits({3'b000, hours_q});
  assign d_dom = to_digits(dom1);
  assign d_mon = to_digits({4'b0000, mon_q} + 8'd1);
  assign d_yr  = to_digits(yr_q);

  always_comb begin
    acc_d   = acc_q;
    quo_d   = quo_q;
    day_d   = day_q;
    yr_d    = yr_q;
    mon_d   = mon_q;
    hours_d = hours_q;
    mins_d  = mins_q;
    wday_d  = wday_q;
    case (ctrl_i.op)
      OpLoad: begin
        if (in_valid_i) begin
          acc_d = 33'($signed({epoch_seconds_i[31], epoch_seconds_i})) + SecsBias;
          yr_d  = EpochYear;
          mon_d = '0;
        end
      end
      OpDayQuo: begin
        quo_d = day_prod[50:35];
      end
      OpSplit: begin
        day_d  = day_wide[15:0];
        wday_d = mod7({1'b0, quo_q} + WdayBias);
        acc_d  = acc_q - day_back;
      end
      OpHours: begin
        hours_d = hour_prod[31:27];
      end
      OpMinRem: begin
        acc_d = acc_q - {16'b0, hour_back};
      end
      OpMins: begin
        mins_d = min_prod[22:17];
      end
      OpYearBack: begin
        if (stat_o.day_neg) begin
          day_d = day_q + FourYrDays;
          yr_d  = yr_q - 8'd4;
        end
      end
      OpYearFwd4: begin
        if (stat_o.day_ge4) begin
          day_d = day_q - FourYrDays;
          yr_d  = yr_q + 8'd4;
        end
      end
      OpYearFwd1: begin
        if (stat_o.day_ge_year) begin
          day_d = day_q - year_len;
          yr_d  = yr_q + 8'd1;
        end
      end
      OpMonth: begin
        if (stat_o.mon_go) begin
          day_d = day_q - mon_len;
          mon_d = mon_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_d                = res_q;
    res_d.minute_ones    = d_min.ones;
    res_d.minute_tens    = d_min.tens[2:0];
    res_d.hour_ones      = d_hr.ones;
    res_d.hour_tens_mode = d_hr.tens[3:0] | HourMode;
    res_d.weekday        = wday_q;
    res_d.day_ones       = d_dom.ones;
    res_d.day_tens_leap  = d_dom.tens[2:0] + (leap ? LeapFlag : 3'd0);
    res_d.month_ones     = d_mon.ones;
    res_d.month_tens     = d_mon.tens[0];
    res_d.year_ones      = d_yr.ones;
    res_d.year_tens      = d_yr.tens[3:0];
    out_valid_d          = emit || stat_o.out_busy;
  end

  // Working registers carry no reset.
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    quo_q   <= quo_d;
    day_q   <= day_d;
    yr_q    <= yr_d;
    mon_q   <= mon_d;
    hours_q <= hours_d;
    mins_q  <= mins_d;
    wday_q  <= wday_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/epoch_seconds_to_bcd_datetime.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_bcd_datetime
// From the input beat to the result beat: 5 divide and split steps,
//   the year walk, the month walk, the emit step, then the result beat.
// A new input beat is taken only after the wrap step returns to idle;
//   a result still held by its sink stalls the emit step.
// Reset: rst_ni clears the step counter and the result valid flag at once.
// ----------------------------------------------------------------------------
module epoch_seconds_to_bcd_datetime import epbcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  epbcd_in_if.sink    in_i,
  epbcd_out_if.source res_o
);

  // The sequencer steps a 12-word program. Each word names one datapath
  // operation and one branch condition:
  //   idle      wait for an input beat, bias it to a nonnegative dividend
  //   day quo   biased day by reciprocal multiply (86400 is 675 << 7)
  //   split     unbias the day, take the weekday residue, keep the time of day
  //   hours     hour of the day by reciprocal multiply
  //   min rem   drop whole hours from the time of day
  //   mins      minute of the hour by reciprocal multiply
  //   year walk bring the day up to zero by four-year blocks, drop whole
  //             four-year blocks, then single years
  //   month     drop whole months, February one day longer in leap years
  //   emit      load the BCD result register once it is free, then wrap
  // The result register decouples the output: a new beat is taken while a
  // finished result still waits for its sink.

  ctrl_t ctrl;
  stat_t stat;

  epbcd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  epbcd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .in_valid_i      (in_i.valid),
    .epoch_seconds_i (in_i.epoch_seconds),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .res_o           (res_o.data),
    .stat_o          (stat)
  );

  // Accept a beat only on the idle step.
  assign in_i.ready = ctrl.idle;

endmodule

FILE: tb/epoch_bcd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_bcd_checker
// Watches the epoch input channel and the BCD result channel. It predicts the
// calendar digits of every accepted input beat and compares each result beat
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module epoch_bcd_checker import epbcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  epbcd_in_if  in_i,
  epbcd_out_if res_i,
  output int   pending_o,
  output int   errors_o
);

  localparam longint SecsInDay    = 86400;
  localparam longint WeekdayShift = 7340036;
  localparam int     BaseYear     = 70;
  localparam int     LastMonthIdx = 11;
  localparam int     PrintCap     = 100;
  localparam logic [3:0] Mode24   = 4'h8;
  localparam logic [2:0] LeapMark = 3'd4;
  localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  res_t expected_dates [$];
  int   mismatch_total = 0;

  function automatic int days_in_year(input int yr);
    return (yr[1:0] == 2'd0) ? 366 : 365;
  endfunction

  function automatic res_t calendar_digits(input logic signed [31:0] secs);
    longint total;
    longint day_num;
    longint tod;
    int     mins;
    int     hrs;
    int     wday;
    int     yr;
    int     mon;
    int     dom;
    int     mlen;
    bit     leap;
    res_t   r;
    total   = longint'(secs);
    tod     = total % SecsInDay;
    day_num = total / SecsInDay;
    // borrow a day so the time of day is never negative
    if (tod < 0) begin
      tod     = tod + SecsInDay;
      day_num = day_num - 1;
    end
    mins = int'((tod / 60) % 60);
    hrs  = int'(tod / 3600);
    wday = int'((day_num + WeekdayShift) % 7);
    yr   = BaseYear;
    if (day_num >= 0) begin
      while (day_num >= days_in_year(yr)) begin
        day_num = day_num - days_in_year(yr);
        yr++;
      end
    end else begin
      while (day_num < 0) begin
        day_num = day_num + days_in_year(yr - 1);
        yr--;
      end
    end
    leap = (days_in_year(yr) == 366);
    dom  = int'(day_num);
    mon  = 0;
    while (mon < LastMonthIdx) begin
      mlen = MonthDays[mon] + ((mon == 1 && leap) ? 1 : 0);
      if (dom < mlen) break;
      dom = dom - mlen;
      mon++;
    end
    r.minute_ones    = 4'(mins % 10);
    r.minute_tens    = 3'(mins / 10);
    r.hour_ones      = 4'(hrs % 10);
    r.hour_tens_mode = 4'(hrs / 10) | Mode24;
    r.weekday        = 3'(wday);
    r.day_ones       = 4'((dom + 1) % 10);
    r.day_tens_leap  = 3'((dom + 1) / 10) + (leap ? LeapMark : 3'd0);
    r.month_ones     = 4'((mon + 1) % 10);
    r.month_tens     = 1'((mon + 1) / 10);
    r.year_ones      = 4'(yr % 10);
    r.year_tens      = 4'(yr / 10);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_total < PrintCap) $display("%0t: mismatch: %s", $time, what);
    mismatch_total++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      pending_o <= 0;
      errors_o  <= mismatch_total;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("result beat with no input beat outstanding");
        end else begin
          want = expected_dates.pop_front();
          check_field("minute_ones", res_i.data.minute_ones, want.minute_ones);
          check_field("minute_tens", res_i.data.minute_tens, want.minute_tens);
          check_field("hour_ones", res_i.data.hour_ones, want.hour_ones);
          check_field("hour_tens_mode", res_i.data.hour_tens_mode, want.hour_tens_mode);
          check_field("weekday", res_i.data.weekday, want.weekday);
          check_field("day_ones", res_i.data.day_ones, want.day_ones);
          check_field("day_tens_leap", res_i.data.day_tens_leap, want.day_tens_leap);
          check_field("month_ones", res_i.data.month_ones, want.month_ones);
          check_field("month_tens", res_i.data.month_tens, want.month_tens);
          check_field("year_ones", res_i.data.year_ones, want.year_ones);
          check_field("year_tens", res_i.data.year_tens, want.year_tens);
        end
      end
      if (in_i.valid && in_i.ready) begin
        expected_dates.push_back(calendar_digits(in_i.epoch_seconds));
      end
      pending_o <= expected_dates.size();
      errors_o  <= mismatch_total;
    end
  end

endmodule

FILE: tb/tb_epoch_seconds_to_bcd_datetime.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_bcd_datetime
// Drives signed epoch seconds into the date block and lets the checker
// compare every BCD result beat. Corner times come first, then a random mix
// of full-range values, day edges and dates near the epoch, sent in bursts
// against a stalling receiver.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_bcd_datetime;

  localparam int     ClkHalf     = 5;
  localparam int     ResetCycles = 4;
  localparam int     RandomBeats = 1230;
  localparam int     IdleLimit   = 4000;
  // worst latency of the block plus margin
  localparam int     DrainCycles = 80;
  localparam longint DaySecs     = 86400;
  // day numbers that the signed 32-bit range covers
  localparam int     DayLow      = -24856;
  localparam int     DayHigh     = 24855;
  // a few years either side of the epoch
  localparam int     NearSpan    = 1600 * 86400;
  localparam int     NearShift   = 800 * 86400;

  // Corner times: the epoch, both ends of the range, minute/hour/day edges,
  // times just before the epoch that borrow a day, leap days on both sides of
  // the epoch, year ends and alternating bit patterns.
  localparam logic [31:0] CornerEpochs [24] = '{
    0, -1, 32'h8000_0000, 32'h7FFF_FFFF,
    59, 60, 3599, 3600,
    86399, 86400, -60, -86400,
    -86401, 68169600, 951782400, 951868800,
    946684799, 978307199, -58060800, 1700000000,
    32'h5555_5555, 32'hAAAA_AAAA, 1000000000, -1000000000
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  int   pending;
  int   errors;
  int   idle_cycles = 0;
  int   burst_left  = 0;

  epbcd_in_if  in_if ();
  epbcd_out_if res_if ();

  epoch_seconds_to_bcd_datetime dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .res_o (res_if)
  );

  epoch_bcd_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_if),
    .res_i    (res_if),
    .pending_o(pending),
    .errors_o (errors)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Send one beat. At the start of each burst, drop valid for a random gap
  // so idle time lands on every phase of the block's work; within a burst,
  // hold valid high and swap the payload right at the accepting edge.
  task automatic send_epoch(input logic [31:0] secs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid         <= 1'b1;
    in_if.epoch_seconds <= secs;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Drop valid and hold off until the checker has nothing outstanding. Step
  // one edge first so a beat accepted just now is already counted.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    burst_left  = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [31:0] secs;
    longint      tod;
    int          day_pick;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.epoch_seconds <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (CornerEpochs[k]) send_epoch(CornerEpochs[k]);
    wait_drained();

    for (int n = 0; n < RandomBeats; n++) begin
      // hold off once more midway with the pipeline empty
      if (n == RandomBeats / 2) wait_drained();
      case ($urandom_range(0, 4))
        0, 1: begin
          secs = $urandom;
        end
        2, 3: begin
          // land on a random day at midnight, one second before midnight,
          // the last minute, or anywhere in the day
          day_pick = $urandom_range(0, DayHigh - DayLow) + DayLow;
          case ($urandom_range(0, 3))
            0:       tod = 0;
            1:       tod = DaySecs - 1;
            2:       tod = DaySecs - 60;
            default: tod = $urandom_range(0, DaySecs - 1);
          endcase
          secs = 32'(longint'(day_pick) * DaySecs + tod);
        end
        default: begin
          secs = 32'($urandom_range(0, NearSpan)) - 32'(NearShift);
        end
      endcase
      send_epoch(secs);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stall the result channel in spans: always ready, coin flips, a rotating
  // byte pattern, or heavy backpressure.
  initial begin : result_sink
    int         span;
    int         style;
    logic [7:0] pattern;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      span    = $urandom_range(20, 200);
      style   = $urandom_range(0, 3);
      pattern = 8'($urandom);
      repeat (span) begin
        @(posedge clk_i);
        case (style)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 1) == 1);
          2: begin
            res_if.ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
          default: res_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Count cycles with no beat on either channel; give up when the count
  // passes anything a correct run can need.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/epbcd_pkg.sv
rtl/epbcd_if.sv
rtl/epbcd_seq.sv
rtl/epbcd_dp.sv
rtl/epoch_seconds_to_bcd_datetime.sv
tb/epoch_bcd_checker.sv
tb/tb_epoch_seconds_to_bcd_datetime.sv
